// ===== hw/rtl/mcto_pkg.sv =====
// Shared types, constants and helper functions for the multi-channel timeout timer.
// No dependencies; used by mcto_exec and multi_channel_timeout_timer.

package mcto_pkg;

   // Sizes
   localparam int PERIOD_CHANNELS = 4;
   localparam int WORD_W          = 32;
   localparam int CMD_W           = 4;
   localparam int CH_W            = 2;
   localparam int CSR_IDX_W       = 1;

   // Request beat: tuser = {channel, command}, tdata = amount
   localparam int REQ_TUSER_W = CMD_W + CH_W;
   localparam int REQ_TDATA_W = WORD_W;

   localparam logic [WORD_W-1:0] RESET_DEFAULT_LIMIT = 32'd60000;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK         = 4'd0,
      CMD_START_GLOBAL = 4'd1,
      CMD_STOP_GLOBAL  = 4'd2,
      CMD_SET_STEP     = 4'd3,
      CMD_RESTART_STEP = 4'd4,
      CMD_STOP_STEP    = 4'd5,
      CMD_SET_DELAY    = 4'd6,
      CMD_CANCEL_DELAY = 4'd7,
      CMD_POLL_DELAY   = 4'd8,
      CMD_START_PERIOD = 4'd9,
      CMD_STOP_PERIOD  = 4'd10,
      CMD_POLL_PERIOD  = 4'd11
   } cmd_type;

   typedef enum logic [1:0] {
      TO_NONE   = 2'd0,
      TO_GLOBAL = 2'd1,
      TO_STEP   = 2'd2
   } tcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE        = 1'b0,
      CSR_DEFAULT_LIMIT = 1'b1
   } csr_idx_type;

   // Live configuration handed to the execution unit
   typedef struct packed {
      logic              enable;
      logic [WORD_W-1:0] default_limit;
   } cfg_type;

   // Result fields, last field in the lowest bits
   typedef struct packed {
      logic              period_fired;
      logic              delay_done;
      logic              delay_running;
      logic [WORD_W-1:0] delay_left;
      logic [WORD_W-1:0] step_left;
      logic [WORD_W-1:0] global_left;
      tcode_type         timeout_code;
      logic [WORD_W-1:0] tick_now;
   } rsp_type;

   localparam int RSP_FIELDS_W = $bits(rsp_type);
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Wrap-around elapsed ticks
   function automatic logic [WORD_W-1:0] since(input logic [WORD_W-1:0] now,
                                               input logic [WORD_W-1:0] start);
      return now - start;
   endfunction

   function automatic logic timed_out(input logic              on,
                                      input logic [WORD_W-1:0] now,
                                      input logic [WORD_W-1:0] start,
                                      input logic [WORD_W-1:0] limit);
      return on && (since(now, start) >= limit);
   endfunction

   function automatic logic [WORD_W-1:0] time_left(input logic              on,
                                                   input logic [WORD_W-1:0] now,
                                                   input logic [WORD_W-1:0] start,
                                                   input logic [WORD_W-1:0] limit);
      logic [WORD_W-1:0] el;
      el = since(now, start);
      if (!on || el >= limit) begin
         return '0;
      end
      return limit - el;
   endfunction

endpackage

// ===== hw/rtl/multi_channel_timeout_timer.sv =====
// A command passes through the request register, then execution into the result
// register, before its result beat is offered on rsp_tvalid.
// Throughput: one command per cycle while the result side is not stalled; an rsp
// stall holds the command in the request register and drops req_tready in the same
// cycle, so at most two are in flight.
// Configuration writes are taken every cycle (csr_ready is always high).
// Synchronous active-high reset clears all channels, the tick counter, the
// enable bit and sets the default global limit to 60000.
// Top level; depends on mcto_pkg and mcto_exec.

module multi_channel_timeout_timer (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mcto_pkg::REQ_TDATA_W-1:0]      req_tdata,  // [31:0] amount
   input  logic [mcto_pkg::REQ_TUSER_W-1:0]      req_tuser,  // [3:0] command, [5:4] channel
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] tick_now, [33:32] timeout_code, [65:34] global_left,
   // [97:66] step_left, [129:98] delay_left, [130] delay_running,
   // [131] delay_done, [132] period_fired, [135:133] zero
   output logic [mcto_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mcto_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mcto_pkg::WORD_W-1:0]           csr_data
);

   localparam int W = mcto_pkg::WORD_W;

   mcto_pkg::cfg_type           cfg_ff;
   logic                        s1_valid_ff;
   mcto_pkg::cmd_type           s1_cmd_ff;
   logic [mcto_pkg::CH_W-1:0]   s1_ch_ff;
   logic [W-1:0]                s1_amount_ff;
   logic                        s1_adv;
   logic                        req_fire;
   logic                        rsp_valid_ff;
   mcto_pkg::rsp_type           rsp_ff, rsp_in;

   // Handshake
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(mcto_pkg::RSP_TDATA_W - mcto_pkg::RSP_FIELDS_W)'(0), rsp_ff};

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.default_limit <= mcto_pkg::RESET_DEFAULT_LIMIT;
      end else if (csr_valid && csr_ready) begin
         unique case (mcto_pkg::csr_idx_type'(csr_index))
            mcto_pkg::CSR_ENABLE:        cfg_ff.enable        <= csr_data[0];
            mcto_pkg::CSR_DEFAULT_LIMIT: cfg_ff.default_limit <= csr_data;
            default: ;
         endcase
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff    <= mcto_pkg::cmd_type'(req_tuser[mcto_pkg::CMD_W-1:0]);
         s1_ch_ff     <= req_tuser[mcto_pkg::CMD_W +: mcto_pkg::CH_W];
         s1_amount_ff <= req_tdata;
      end
   end

   // Command execution and timer state
   mcto_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .exec_en (s1_adv),
      .cmd     (s1_cmd_ff),
      .channel (s1_ch_ff),
      .amount  (s1_amount_ff),
      .cfg     (cfg_ff),
      .result  (rsp_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // An accepted beat always lands in the request register
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request beat lost");

   // A committed command always shows up as a result beat
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("executed command produced no result beat");

   // A held request is not executed twice or dropped while the output stalls
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_amount_ff)))
      else $error("stalled request beat changed");

   // Step expiry is only reported when no step time is left
   a_step_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.timeout_code == mcto_pkg::TO_STEP) |->
         (rsp_ff.step_left == '0))
      else $error("step timeout reported with ticks remaining");

endmodule

// ===== hw/rtl/mcto_exec.sv =====
// Execution unit: timer state registers, command decode and result computation.
// Depends on mcto_pkg.

module mcto_exec (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                exec_en,  // commit one command
   input  mcto_pkg::cmd_type                   cmd,
   input  logic [mcto_pkg::CH_W-1:0]           channel,
   input  logic [mcto_pkg::WORD_W-1:0]         amount,
   input  mcto_pkg::cfg_type                   cfg,
   output mcto_pkg::rsp_type                   result
);

   localparam int NCH = mcto_pkg::PERIOD_CHANNELS;
   localparam int W   = mcto_pkg::WORD_W;

   logic [W-1:0]   tick_ff, tick_in;
   logic           glob_on_ff, glob_on_in;
   logic [W-1:0]   glob_begin_ff, glob_begin_in, glob_limit_ff, glob_limit_in;
   logic           step_on_ff, step_on_in;
   logic [W-1:0]   step_begin_ff, step_begin_in, step_limit_ff, step_limit_in;
   logic           dly_on_ff, dly_on_in;
   logic [W-1:0]   dly_begin_ff, dly_begin_in, dly_limit_ff, dly_limit_in;
   logic [NCH-1:0] per_on_ff, per_on_in;
   logic [W-1:0]   per_begin_ff [NCH];
   logic [W-1:0]   per_begin_in [NCH];
   logic [W-1:0]   per_ival_ff  [NCH];
   logic [W-1:0]   per_ival_in  [NCH];

   logic [NCH-1:0] ch_hit;
   logic           sel_on;
   logic [W-1:0]   sel_begin, sel_ival;
   logic           done, fired;

   // Channel decode; an out-of-range channel hits nothing
   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         ch_hit[i] = (32'(channel) == 32'(i));
      end
   end

   // Selected periodic channel
   always_comb begin
      sel_on    = 1'b0;
      sel_begin = '0;
      sel_ival  = '0;
      for (int i = 0; i < NCH; i++) begin
         sel_on    = sel_on | (ch_hit[i] & per_on_ff[i]);
         sel_begin = sel_begin | (per_begin_ff[i] & {W{ch_hit[i]}});
         sel_ival  = sel_ival | (per_ival_ff[i] & {W{ch_hit[i]}});
      end
   end

   // Next state
   always_comb begin
      tick_in       = tick_ff;
      glob_on_in    = glob_on_ff;
      glob_begin_in = glob_begin_ff;
      glob_limit_in = glob_limit_ff;
      step_on_in    = step_on_ff;
      step_begin_in = step_begin_ff;
      step_limit_in = step_limit_ff;
      dly_on_in     = dly_on_ff;
      dly_begin_in  = dly_begin_ff;
      dly_limit_in  = dly_limit_ff;
      per_on_in     = per_on_ff;
      per_begin_in  = per_begin_ff;
      per_ival_in   = per_ival_ff;
      done          = 1'b0;
      fired         = 1'b0;
      unique case (cmd)
         mcto_pkg::CMD_TICK: begin
            if (cfg.enable) begin
               tick_in = tick_ff + W'(1);
            end
         end
         mcto_pkg::CMD_START_GLOBAL: begin
            glob_limit_in = (amount != '0) ? amount : cfg.default_limit;
            glob_begin_in = tick_ff;
            glob_on_in    = 1'b1;
         end
         mcto_pkg::CMD_STOP_GLOBAL: glob_on_in = 1'b0;
         mcto_pkg::CMD_SET_STEP: begin
            step_limit_in = amount;
            step_begin_in = tick_ff;
            step_on_in    = 1'b1;
         end
         mcto_pkg::CMD_RESTART_STEP: begin
            if (step_on_ff) begin
               step_begin_in = tick_ff;
            end
         end
         mcto_pkg::CMD_STOP_STEP: step_on_in = 1'b0;
         mcto_pkg::CMD_SET_DELAY: begin
            dly_limit_in = amount;
            dly_begin_in = tick_ff;
            dly_on_in    = 1'b1;
         end
         mcto_pkg::CMD_CANCEL_DELAY: dly_on_in = 1'b0;
         mcto_pkg::CMD_POLL_DELAY: begin
            // inactive delay polls as done; an elapsed one clears itself
            if (!dly_on_ff) begin
               done = 1'b1;
            end else if (mcto_pkg::timed_out(1'b1, tick_ff, dly_begin_ff, dly_limit_ff)) begin
               dly_on_in = 1'b0;
               done      = 1'b1;
            end
         end
         mcto_pkg::CMD_START_PERIOD: begin
            for (int i = 0; i < NCH; i++) begin
               if (ch_hit[i]) begin
                  per_ival_in[i]  = amount;
                  per_begin_in[i] = tick_ff;
                  per_on_in[i]    = 1'b1;
               end
            end
         end
         mcto_pkg::CMD_STOP_PERIOD: begin
            for (int i = 0; i < NCH; i++) begin
               if (ch_hit[i]) begin
                  per_on_in[i] = 1'b0;
               end
            end
         end
         mcto_pkg::CMD_POLL_PERIOD: begin
            fired = mcto_pkg::timed_out(sel_on, tick_ff, sel_begin, sel_ival);
            for (int i = 0; i < NCH; i++) begin
               if (ch_hit[i] && fired) begin
                  per_begin_in[i] = tick_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // Result from the state as it stands after the command
   always_comb begin
      result.tick_now = tick_in;
      if (mcto_pkg::timed_out(glob_on_in, tick_in, glob_begin_in, glob_limit_in)) begin
         result.timeout_code = mcto_pkg::TO_GLOBAL;
      end else if (mcto_pkg::timed_out(step_on_in, tick_in, step_begin_in, step_limit_in)) begin
         result.timeout_code = mcto_pkg::TO_STEP;
      end else begin
         result.timeout_code = mcto_pkg::TO_NONE;
      end
      result.global_left   = mcto_pkg::time_left(glob_on_in, tick_in, glob_begin_in,
                                                 glob_limit_in);
      result.step_left     = mcto_pkg::time_left(step_on_in, tick_in, step_begin_in,
                                                 step_limit_in);
      result.delay_left    = mcto_pkg::time_left(dly_on_in, tick_in, dly_begin_in,
                                                 dly_limit_in);
      result.delay_running = dly_on_in;
      result.delay_done    = done;
      result.period_fired  = fired;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         glob_on_ff <= 1'b0;
         step_on_ff <= 1'b0;
         dly_on_ff  <= 1'b0;
         per_on_ff  <= '0;
      end else if (exec_en) begin
         tick_ff    <= tick_in;
         glob_on_ff <= glob_on_in;
         step_on_ff <= step_on_in;
         dly_on_ff  <= dly_on_in;
         per_on_ff  <= per_on_in;
      end
   end

   // Start ticks and limits, only meaningful while the matching on bit is set
   always_ff @(posedge clock) begin
      if (exec_en) begin
         glob_begin_ff <= glob_begin_in;
         glob_limit_ff <= glob_limit_in;
         step_begin_ff <= step_begin_in;
         step_limit_ff <= step_limit_in;
         dly_begin_ff  <= dly_begin_in;
         dly_limit_ff  <= dly_limit_in;
         per_begin_ff  <= per_begin_in;
         per_ival_ff   <= per_ival_in;
      end
   end

   // Tick counter only moves on an enabled tick command
   a_tick_source: assert property (@(posedge clock) disable iff (reset)
      (exec_en && !(cmd == mcto_pkg::CMD_TICK && cfg.enable)) |=> $stable(tick_ff))
      else $error("tick counter moved without an enabled tick");

endmodule

// ===== verif/multi_channel_timeout_timer_tb.sv =====
// Self-checking testbench for multi_channel_timeout_timer: drives command beats,
// predicts every result beat with its own model of the timer bank and checks it.
// Depends on mcto_pkg and the multi_channel_timeout_timer RTL.

module multi_channel_timeout_timer_tb;

   localparam int W = mcto_pkg::WORD_W;
   localparam logic [mcto_pkg::CMD_W-1:0] CMD_SPARE_LO = 4'd12;
   localparam logic [mcto_pkg::CMD_W-1:0] CMD_SPARE_HI = 4'd15;
   localparam int QUIET_LIMIT    = 500;
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_CYCLES    = 60;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [mcto_pkg::REQ_TDATA_W-1:0]    req_tdata = '0;  // [31:0] amount
   logic [mcto_pkg::REQ_TUSER_W-1:0]    req_tuser = '0;  // [3:0] command, [5:4] channel
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // [31:0] tick_now, [33:32] timeout_code, [65:34] global_left,
   // [97:66] step_left, [129:98] delay_left, [130] delay_running,
   // [131] delay_done, [132] period_fired, [135:133] zero
   logic [mcto_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [mcto_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [W-1:0]                        csr_data = '0;

   multi_channel_timeout_timer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Timer bank as the testbench sees it
   logic         cfg_enable        = 1'b0;
   logic [W-1:0] cfg_default_limit = mcto_pkg::RESET_DEFAULT_LIMIT;
   logic [W-1:0] tick_ctr   = '0;
   logic         glob_on    = 1'b0;
   logic [W-1:0] glob_start = '0;
   logic [W-1:0] glob_lim   = '0;
   logic         step_on    = 1'b0;
   logic [W-1:0] step_start = '0;
   logic [W-1:0] step_lim   = '0;
   logic         delay_on   = 1'b0;
   logic [W-1:0] delay_start = '0;
   logic [W-1:0] delay_lim   = '0;
   logic         per_on    [mcto_pkg::PERIOD_CHANNELS] = '{default: 1'b0};
   logic [W-1:0] per_start [mcto_pkg::PERIOD_CHANNELS] = '{default: '0};
   logic [W-1:0] per_ivl   [mcto_pkg::PERIOD_CHANNELS] = '{default: '0};

   mcto_pkg::rsp_type timer_reports_due[$];

   int  fail_count    = 0;
   int  items_sent    = 0;
   int  reports_seen  = 0;
   int  timeouts_seen = 0;
   int  fires_seen    = 0;
   int  polls_done    = 0;
   bit  req_held      = 1'b0;
   bit  req_steady    = 1'b0;
   bit  rsp_steady    = 1'b0;
   int  rsp_hold_cycles = 0;

   function automatic logic [W-1:0] elapsed_ticks(input logic [W-1:0] start);
      return tick_ctr - start;
   endfunction

   function automatic logic [W-1:0] ticks_left(input logic         on,
                                              input logic [W-1:0] start,
                                              input logic [W-1:0] lim);
      logic [W-1:0] el;
      el = elapsed_ticks(start);
      if (!on || el >= lim) begin
         return '0;
      end
      return lim - el;
   endfunction

   // Applies one command to the timer bank and returns the report it should give
   function automatic mcto_pkg::rsp_type predict_timer_report(
         input logic [mcto_pkg::CMD_W-1:0] cmd,
         input logic [mcto_pkg::CH_W-1:0]  ch,
         input logic [W-1:0]               amount);
      mcto_pkg::rsp_type rep;
      logic    ch_ok;
      logic    done;
      logic    fired;
      ch_ok = (int'(ch) < mcto_pkg::PERIOD_CHANNELS);
      done  = 1'b0;
      fired = 1'b0;
      case (cmd)
         mcto_pkg::CMD_TICK: begin
            if (cfg_enable) tick_ctr = tick_ctr + 1'b1;
         end
         mcto_pkg::CMD_START_GLOBAL: begin
            glob_lim   = (amount != '0) ? amount : cfg_default_limit;
            glob_start = tick_ctr;
            glob_on    = 1'b1;
         end
         mcto_pkg::CMD_STOP_GLOBAL: glob_on = 1'b0;
         mcto_pkg::CMD_SET_STEP: begin
            step_lim   = amount;
            step_start = tick_ctr;
            step_on    = 1'b1;
         end
         mcto_pkg::CMD_RESTART_STEP: begin
            if (step_on) step_start = tick_ctr;
         end
         mcto_pkg::CMD_STOP_STEP: step_on = 1'b0;
         mcto_pkg::CMD_SET_DELAY: begin
            delay_lim   = amount;
            delay_start = tick_ctr;
            delay_on    = 1'b1;
         end
         mcto_pkg::CMD_CANCEL_DELAY: delay_on = 1'b0;
         mcto_pkg::CMD_POLL_DELAY: begin
            if (!delay_on) begin
               done = 1'b1;
            end else if (elapsed_ticks(delay_start) >= delay_lim) begin
               delay_on = 1'b0;
               done     = 1'b1;
            end
         end
         mcto_pkg::CMD_START_PERIOD: begin
            if (ch_ok) begin
               per_ivl[ch]   = amount;
               per_start[ch] = tick_ctr;
               per_on[ch]    = 1'b1;
            end
         end
         mcto_pkg::CMD_STOP_PERIOD: begin
            if (ch_ok) per_on[ch] = 1'b0;
         end
         mcto_pkg::CMD_POLL_PERIOD: begin
            if (ch_ok && per_on[ch] && elapsed_ticks(per_start[ch]) >= per_ivl[ch]) begin
               per_start[ch] = tick_ctr;
               fired         = 1'b1;
            end
         end
         default: ;
      endcase

      // global outranks step
      if (glob_on && elapsed_ticks(glob_start) >= glob_lim) begin
         rep.timeout_code = mcto_pkg::TO_GLOBAL;
      end else if (step_on && elapsed_ticks(step_start) >= step_lim) begin
         rep.timeout_code = mcto_pkg::TO_STEP;
      end else begin
         rep.timeout_code = mcto_pkg::TO_NONE;
      end
      rep.tick_now      = tick_ctr;
      rep.global_left   = ticks_left(glob_on, glob_start, glob_lim);
      rep.step_left     = ticks_left(step_on, step_start, step_lim);
      rep.delay_left    = ticks_left(delay_on, delay_start, delay_lim);
      rep.delay_running = delay_on;
      rep.delay_done    = done;
      rep.period_fired  = fired;
      if (rep.timeout_code != mcto_pkg::TO_NONE) timeouts_seen++;
      if (fired) fires_seen++;
      if (done) polls_done++;
      return rep;
   endfunction

   // Offer one command beat; valid stays up when the next beat follows at once
   task automatic send_cmd(input logic [mcto_pkg::CMD_W-1:0] cmd,
                           input logic [mcto_pkg::CH_W-1:0]  ch,
                           input logic [W-1:0]               amount);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         if (req_held) begin
            req_tvalid <= 1'b0;
            req_held = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {ch, cmd};
      req_tdata  <= amount;
      req_held = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      timer_reports_due.push_back(predict_timer_report(cmd, ch, amount));
      items_sent++;
   endtask

   // Drop valid and wait until every report is back and the pipeline is empty
   task automatic settle();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end
      while (timer_reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input mcto_pkg::csr_idx_type idx, input logic [W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         mcto_pkg::CSR_ENABLE:        cfg_enable = value[0];
         mcto_pkg::CSR_DEFAULT_LIMIT: cfg_default_limit = value;
         default: ;
      endcase
   endtask

   function automatic logic [mcto_pkg::CMD_W-1:0] pick_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return mcto_pkg::CMD_TICK;
      if (roll < 97) begin
         return mcto_pkg::CMD_W'($urandom_range(mcto_pkg::CMD_START_GLOBAL,
                                                mcto_pkg::CMD_POLL_PERIOD));
      end
      return mcto_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
   endfunction

   // Mostly short limits so that channels expire and fire within a phase
   function automatic logic [W-1:0] pick_amount();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return W'($urandom_range(0, 24));
      if (roll < 90) return $urandom();
      return 32'hFFFF_FFFF - W'($urandom_range(0, 24));
   endfunction

   // Ticks while disabled, inactive channels, spare commands
   task automatic test_disabled_bank();
      send_cmd(mcto_pkg::CMD_TICK, '0, 32'hFFFF_FFFF);
      send_cmd(mcto_pkg::CMD_RESTART_STEP, '0, '0);
      send_cmd(mcto_pkg::CMD_POLL_DELAY, '0, '0);
      send_cmd(CMD_SPARE_LO, 2'd3, 32'hFFFF_FFFF);
      send_cmd(CMD_SPARE_HI, 2'd1, 32'h5555_AAAA);
      settle();
   endtask

   // Global, step and delay channels: expiry, zero limits
   task automatic test_one_shot_channels();
      write_reg(mcto_pkg::CSR_ENABLE, 32'd1);
      send_cmd(mcto_pkg::CMD_START_GLOBAL, '0, '0);
      send_cmd(mcto_pkg::CMD_SET_STEP, '0, 32'd2);
      send_cmd(mcto_pkg::CMD_SET_DELAY, '0, 32'd1);
      send_cmd(mcto_pkg::CMD_TICK, '0, '0);
      send_cmd(mcto_pkg::CMD_POLL_DELAY, '0, '0);
      send_cmd(mcto_pkg::CMD_TICK, '0, '0);
      send_cmd(mcto_pkg::CMD_RESTART_STEP, '0, '0);
      send_cmd(mcto_pkg::CMD_SET_STEP, '0, '0);
      send_cmd(mcto_pkg::CMD_SET_DELAY, '0, '0);
      send_cmd(mcto_pkg::CMD_START_GLOBAL, '0, 32'hFFFF_FFFF);
      send_cmd(mcto_pkg::CMD_STOP_GLOBAL, '0, '0);
      send_cmd(mcto_pkg::CMD_STOP_STEP, '0, '0);
      send_cmd(mcto_pkg::CMD_CANCEL_DELAY, '0, '0);
      settle();
   endtask

   // Periodic channels: zero interval, firing and reload, stop
   task automatic test_periodic_channels();
      send_cmd(mcto_pkg::CMD_START_PERIOD, 2'd3, '0);
      send_cmd(mcto_pkg::CMD_POLL_PERIOD, 2'd3, '0);
      send_cmd(mcto_pkg::CMD_START_PERIOD, 2'd0, 32'd1);
      send_cmd(mcto_pkg::CMD_POLL_PERIOD, 2'd0, '0);
      send_cmd(mcto_pkg::CMD_TICK, '0, '0);
      send_cmd(mcto_pkg::CMD_POLL_PERIOD, 2'd0, '0);
      send_cmd(mcto_pkg::CMD_STOP_PERIOD, 2'd0, '0);
      send_cmd(mcto_pkg::CMD_POLL_PERIOD, 2'd0, '0);
      settle();
   endtask

   // Fallback limit for a zero start amount, at zero, one and full scale
   task automatic test_default_limit();
      write_reg(mcto_pkg::CSR_DEFAULT_LIMIT, '0);
      send_cmd(mcto_pkg::CMD_START_GLOBAL, '0, '0);
      settle();
      write_reg(mcto_pkg::CSR_DEFAULT_LIMIT, 32'd1);
      send_cmd(mcto_pkg::CMD_START_GLOBAL, '0, '0);
      send_cmd(mcto_pkg::CMD_TICK, '0, '0);
      settle();
      write_reg(mcto_pkg::CSR_DEFAULT_LIMIT, 32'hFFFF_FFFF);
      send_cmd(mcto_pkg::CMD_START_GLOBAL, '0, '0);
      settle();
   endtask

   // Random command mix under one register setting, idling in stretches
   task automatic test_random_traffic(input logic         enable,
                                      input logic [W-1:0] default_limit,
                                      input int           count);
      write_reg(mcto_pkg::CSR_ENABLE, {31'd0, enable});
      write_reg(mcto_pkg::CSR_DEFAULT_LIMIT, default_limit);
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
         end
         send_cmd(pick_command(), mcto_pkg::CH_W'($urandom_range(0, 3)), pick_amount());
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      settle();
   endtask

   // Result side holds off while commands keep coming back to back
   task automatic test_backpressure(input int count);
      write_reg(mcto_pkg::CSR_ENABLE, 32'd1);
      write_reg(mcto_pkg::CSR_DEFAULT_LIMIT, 32'd20);
      rsp_hold_cycles = HOLD_CYCLES;
      req_steady = 1'b1;
      for (int i = 0; i < count; i++) begin
         send_cmd(pick_command(), mcto_pkg::CH_W'($urandom_range(0, 3)), pick_amount());
      end
      req_steady = 1'b0;
      settle();
   endtask

   // Result sink: random stall per beat, plus a long hold on request
   initial begin : result_sink
      int stall;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = rsp_steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic check_field(input string name, input logic [W-1:0] want,
                              input logic [W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         fail_count++;
      end
   endtask

   // Compare each result beat with the oldest outstanding report
   always @(posedge clock) begin
      mcto_pkg::rsp_type got;
      mcto_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mcto_pkg::rsp_type'(rsp_tdata[mcto_pkg::RSP_FIELDS_W-1:0]);
         if (timer_reports_due.size() == 0) begin
            $error("result beat with no report outstanding: 0x%h", rsp_tdata);
            fail_count++;
         end else begin
            want = timer_reports_due.pop_front();
            reports_seen++;
            check_field("tick_now", want.tick_now, got.tick_now);
            check_field("timeout_code", 32'(want.timeout_code), 32'(got.timeout_code));
            check_field("global_left", want.global_left, got.global_left);
            check_field("step_left", want.step_left, got.step_left);
            check_field("delay_left", want.delay_left, got.delay_left);
            check_field("delay_running", 32'(want.delay_running), 32'(got.delay_running));
            check_field("delay_done", 32'(want.delay_done), 32'(got.delay_done));
            check_field("period_fired", 32'(want.period_fired), 32'(got.period_fired));
         end
      end
   end

   // Watchdog: ends the run when no beat moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timed out after %0d idle cycles", QUIET_LIMIT);
      $display("multi_channel_timeout_timer regression: fail");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_bank();
      test_one_shot_channels();
      test_periodic_channels();
      test_default_limit();
      test_random_traffic(1'b1, 32'd12, 150);
      test_random_traffic(1'b1, 32'hFFFF_FFFF, 80);
      test_random_traffic(1'b0, 32'd7, 50);
      test_random_traffic(1'b1, '0, 70);
      test_backpressure(60);
      test_random_traffic(1'b1, 32'd1, 40);

      if (timer_reports_due.size() != 0) begin
         $error("%0d reports never arrived", timer_reports_due.size());
         fail_count++;
      end
      $display("%0d commands sent, %0d reports checked across enable and default limit settings",
               items_sent, reports_seen);
      $display("%0d reports with a timeout, %0d period fires, %0d delay polls done",
               timeouts_seen, fires_seen, polls_done);
      if (fail_count == 0) begin
         $display("multi_channel_timeout_timer regression: pass");
      end else begin
         $display("multi_channel_timeout_timer regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mcto_pkg.sv
hw/rtl/mcto_exec.sv
hw/rtl/multi_channel_timeout_timer.sv
verif/multi_channel_timeout_timer_tb.sv
